### src/imf_pkg.sv
// Shared types, constants and helpers of the image median filter.
package imf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 11;
  localparam int EXT_W      = DIM_W + 1;
  localparam int LAG_W      = DIM_W + 1;
  localparam int STORE_ROWS = 5;
  localparam int SLOT_W     = 3;
  localparam int WIN        = 5;
  localparam int NWIN       = WIN * WIN;
  localparam int RANK_W     = 5;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;
  localparam int ADDR_W     = 4;

  // Configuration register indexes.
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WINDOW_FIVE  = 2'd2;

  // Sorted position of the median for each window size.
  localparam logic [RANK_W-1:0] MED_RANK_3 = 5'd4;
  localparam logic [RANK_W-1:0] MED_RANK_5 = 5'd12;

  typedef logic [7:0] pix_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             five;
    logic             restart;
  } imf_cfg_t;

  // One output job: a column read from every bank at two addresses.
  typedef struct packed {
    pix_t [STORE_ROWS-1:0] col_a;
    pix_t [STORE_ROWS-1:0] col_b;
    logic [SLOT_W-1:0]     slot;
    logic [COL_W-1:0]      col;
    logic                  five;
    logic                  border;
    logic                  last;
  } imf_job_t;

  // Reduces a small sum modulo five.
  function automatic logic [SLOT_W-1:0] wrap5(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (r >= 4'd10) begin
      r = r - 4'd10;
    end else if (r >= 4'd5) begin
      r = r - 4'd5;
    end
    return r[SLOT_W-1:0];
  endfunction

endpackage

### src/image_median_filter.sv
// Top level of the streaming 3x3 / 5x5 median filter with its register port.
// A result passes the line store read register, the job queue and the window, compare,
// rank and output registers of the back end.
// Throughput: one transaction per cycle while in_stall is low, set by the single write port of the line store.
// Reset: synchronous, active low; clears positions, queue and valid flags and sets the
// registers to 1024 x 1024, 3x3. Line store contents are left as they are.
module image_median_filter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [7:0]                 in_pixel,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_pixel_out,
  output logic                       out_frame_end,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [imf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [imf_pkg::DIM_W-1:0]  frame_width_r, frame_height_r;
  logic                       window_five_r;
  logic                       wr_en;
  logic [1:0]                 reg_idx;
  imf_pkg::imf_cfg_t          cfg;
  logic                       job_valid, head_valid, pop;
  imf_pkg::imf_job_t          job, head_job;
  logic [imf_pkg::QCNT_W-1:0] q_count;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= imf_pkg::DIM_W'(1024);
      frame_height_r <= imf_pkg::DIM_W'(1024);
      window_five_r  <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        imf_pkg::REG_FRAME_WIDTH:  frame_width_r  <= pwdata[imf_pkg::DIM_W-1:0];
        imf_pkg::REG_FRAME_HEIGHT: frame_height_r <= pwdata[imf_pkg::DIM_W-1:0];
        imf_pkg::REG_WINDOW_FIVE:  window_five_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_idx)
      imf_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_r);
      imf_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_r);
      imf_pkg::REG_WINDOW_FIVE:  prdata = 32'(window_five_r);
      default:                   prdata = '0;
    endcase
  end

  // Effective frame size: zero reads as one, oversize as the maximum.
  always_comb begin
    cfg = '0;
    if (frame_width_r == '0) begin
      cfg.width = imf_pkg::DIM_W'(1);
    end else if (frame_width_r > imf_pkg::DIM_W'(imf_pkg::MAX_WIDTH)) begin
      cfg.width = imf_pkg::DIM_W'(imf_pkg::MAX_WIDTH);
    end else begin
      cfg.width = frame_width_r;
    end
    if (frame_height_r == '0) begin
      cfg.height = imf_pkg::DIM_W'(1);
    end else if (frame_height_r > imf_pkg::DIM_W'(imf_pkg::MAX_HEIGHT)) begin
      cfg.height = imf_pkg::DIM_W'(imf_pkg::MAX_HEIGHT);
    end else begin
      cfg.height = frame_height_r;
    end
    cfg.five    = window_five_r;
    cfg.restart = wr_en && ((reg_idx == imf_pkg::REG_FRAME_WIDTH)
                         || (reg_idx == imf_pkg::REG_FRAME_HEIGHT)
                         || (reg_idx == imf_pkg::REG_WINDOW_FIVE));
  end

  imf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_pixel  (in_pixel),
    .cfg       (cfg),
    .q_count   (q_count),
    .job_valid (job_valid),
    .job       (job)
  );

  imf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_valid),
    .push_job   (job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .count      (q_count)
  );

  imf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (head_valid),
    .job           (head_job),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end)
  );

endmodule

### src/imf_front.sv
// Front end: accepts transactions, tracks positions, owns the line store.
module imf_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [7:0]                 in_pixel,
  input  imf_pkg::imf_cfg_t          cfg,
  input  logic [imf_pkg::QCNT_W-1:0] q_count,
  output logic                       job_valid,
  output imf_pkg::imf_job_t          job
);

  logic [imf_pkg::COL_W-1:0]  in_col_r, in_col_nxt;
  logic [imf_pkg::DIM_W-1:0]  in_row_r, in_row_nxt;
  logic [imf_pkg::SLOT_W-1:0] in_slot_r, in_slot_nxt;
  logic [imf_pkg::COL_W-1:0]  out_col_r, out_col_nxt;
  logic [imf_pkg::DIM_W-1:0]  out_row_r, out_row_nxt;
  logic [imf_pkg::SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [imf_pkg::LAG_W-1:0]  lag_cnt_r, lag_cnt_nxt;

  logic                       f1_valid_r;
  logic [imf_pkg::SLOT_W-1:0] f1_slot_r;
  logic [imf_pkg::COL_W-1:0]  f1_col_r;
  logic                       f1_five_r;
  logic                       f1_border_r;
  logic                       f1_last_r;
  logic [imf_pkg::STORE_ROWS-1:0] fwd_a_r, fwd_b_r;
  logic [7:0]                 fwd_pix_r;
  imf_pkg::pix_t              rd_a_r [imf_pkg::STORE_ROWS];
  imf_pkg::pix_t              rd_b_r [imf_pkg::STORE_ROWS];

  logic                       accept, filling, consume, do_write, emit;
  logic                       border, last;
  logic [1:0]                 margin;
  logic [imf_pkg::LAG_W-1:0]  lag;
  logic [imf_pkg::COL_W-1:0]  addr_a;
  logic [imf_pkg::EXT_W-1:0]  out_col_ext, out_row_ext;

  // Stall when the queue might not take the job now in flight.
  assign in_stall = ({1'b0, q_count} + {3'b000, f1_valid_r}) >= (imf_pkg::QCNT_W + 1)'(imf_pkg::QDEPTH);
  assign accept   = in_valid && !in_stall;

  // Classification of the transaction and position bookkeeping.
  always_comb begin
    margin      = cfg.five ? 2'd2 : 2'd1;
    filling     = in_row_r < cfg.height;
    consume     = accept && !(filling && in_cmd);
    do_write    = accept && filling && !in_cmd;
    lag         = (cfg.five ? {cfg.width, 1'b0} : {1'b0, cfg.width}) + imf_pkg::LAG_W'(margin);
    emit        = consume && (lag_cnt_r >= lag);
    out_col_ext = imf_pkg::EXT_W'(out_col_r);
    out_row_ext = imf_pkg::EXT_W'(out_row_r);
    border      = (out_row_r < imf_pkg::DIM_W'(margin)) || (out_col_ext < imf_pkg::EXT_W'(margin))
               || (out_row_ext + imf_pkg::EXT_W'(margin) >= imf_pkg::EXT_W'(cfg.height))
               || (out_col_ext + imf_pkg::EXT_W'(margin) >= imf_pkg::EXT_W'(cfg.width));
    last        = (out_row_ext + 1'b1 >= imf_pkg::EXT_W'(cfg.height))
               && (out_col_ext + 1'b1 >= imf_pkg::EXT_W'(cfg.width));
    addr_a      = imf_pkg::COL_W'(out_col_ext + imf_pkg::EXT_W'(margin));

    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_slot_nxt  = in_slot_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_slot_nxt = out_slot_r;
    lag_cnt_nxt  = lag_cnt_r;

    if (do_write) begin
      if (imf_pkg::EXT_W'(in_col_r) + 1'b1 >= imf_pkg::EXT_W'(cfg.width)) begin
        in_col_nxt  = '0;
        in_row_nxt  = in_row_r + 1'b1;
        in_slot_nxt = imf_pkg::wrap5(4'(in_slot_r) + 4'd1);
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
    end
    if (consume && !emit) begin
      lag_cnt_nxt = lag_cnt_r + 1'b1;
    end
    if (emit) begin
      if (out_col_ext + 1'b1 >= imf_pkg::EXT_W'(cfg.width)) begin
        out_col_nxt  = '0;
        out_row_nxt  = out_row_r + 1'b1;
        out_slot_nxt = imf_pkg::wrap5(4'(out_slot_r) + 4'd1);
      end else begin
        out_col_nxt = out_col_r + 1'b1;
      end
    end
    // End of frame or a write to one of the three configuration registers starts a new frame.
    if (cfg.restart || (emit && last)) begin
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_slot_nxt  = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_slot_nxt = '0;
      lag_cnt_nxt  = '0;
    end
  end

  // Position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
      lag_cnt_r  <= '0;
      f1_valid_r <= 1'b0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_slot_r  <= in_slot_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_slot_r <= out_slot_nxt;
      lag_cnt_r  <= lag_cnt_nxt;
      f1_valid_r <= emit;
    end
  end

  // Job control travelling with the memory read.
  always_ff @(posedge clk) begin
    if (emit) begin
      f1_slot_r   <= out_slot_r;
      f1_col_r    <= out_col_r;
      f1_five_r   <= cfg.five;
      f1_border_r <= border;
      f1_last_r   <= last;
      fwd_pix_r   <= in_pixel;
    end
  end

  // Line store: one bank per stored row, one write and two reads a cycle.
  for (genvar gb = 0; gb < imf_pkg::STORE_ROWS; gb++) begin : g_bank
    logic [7:0] mem [imf_pkg::MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (do_write && (in_slot_r == imf_pkg::SLOT_W'(gb))) begin
        mem[in_col_r] <= in_pixel;
      end
      if (emit) begin
        rd_a_r[gb]  <= mem[addr_a];
        rd_b_r[gb]  <= mem[out_col_r];
        fwd_a_r[gb] <= do_write && (in_slot_r == imf_pkg::SLOT_W'(gb)) && (in_col_r == addr_a);
        fwd_b_r[gb] <= do_write && (in_slot_r == imf_pkg::SLOT_W'(gb)) && (in_col_r == out_col_r);
      end
    end
  end

  // The pixel written in the same cycle as the read bypasses the store.
  always_comb begin
    job        = '0;
    job.slot   = f1_slot_r;
    job.col    = f1_col_r;
    job.five   = f1_five_r;
    job.border = f1_border_r;
    job.last   = f1_last_r;
    for (int b = 0; b < imf_pkg::STORE_ROWS; b++) begin
      job.col_a[b] = fwd_a_r[b] ? fwd_pix_r : rd_a_r[b];
      job.col_b[b] = fwd_b_r[b] ? fwd_pix_r : rd_b_r[b];
    end
  end

  assign job_valid = f1_valid_r;

endmodule

### src/imf_queue.sv
// Short job queue between the front end and the median back end.
module imf_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  imf_pkg::imf_job_t          push_job,
  input  logic                       pop,
  output logic                       head_valid,
  output imf_pkg::imf_job_t          head_job,
  output logic [imf_pkg::QCNT_W-1:0] count
);

  imf_pkg::imf_job_t          entry_r [imf_pkg::QDEPTH];
  logic [imf_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [imf_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                       do_pop;

  assign head_valid = count_r != '0;
  assign head_job   = entry_r[rd_ptr_r];
  assign count      = count_r;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### src/imf_back.sv
// Back end: window assembly, rank-based median selection and output register.
module imf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  imf_pkg::imf_job_t job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_pixel_out,
  output logic              out_frame_end
);

  logic en;

  // Window stage.
  logic                     w_valid_r;
  logic [7:0]               win_r  [imf_pkg::WIN][imf_pkg::WIN];
  logic [7:0]               bbuf_r [2][imf_pkg::WIN];
  logic [imf_pkg::COL_W-1:0] w_col_r;
  logic                     w_five_r, w_border_r, w_last_r;
  logic [7:0]               col_a_rot [imf_pkg::WIN];
  logic [7:0]               col_b_rot [imf_pkg::WIN];

  // Compare stage.
  logic                     c_valid_r;
  logic [imf_pkg::NWIN-1:0] c_lt_r [imf_pkg::NWIN];
  logic [7:0]               c_val_r [imf_pkg::NWIN];
  logic [imf_pkg::NWIN-1:0] c_act_r;
  logic                     c_five_r, c_border_r, c_last_r;
  logic [7:0]               c_center_r;
  logic [7:0]               comp [imf_pkg::NWIN];
  logic [imf_pkg::NWIN-1:0] act;
  logic [imf_pkg::NWIN-1:0] lt [imf_pkg::NWIN];
  logic [7:0]               center;

  // Rank stage.
  logic                     r_valid_r;
  logic [imf_pkg::RANK_W-1:0] r_rank_r [imf_pkg::NWIN];
  logic [7:0]               r_val_r [imf_pkg::NWIN];
  logic [imf_pkg::NWIN-1:0] r_act_r;
  logic                     r_five_r, r_border_r, r_last_r;
  logic [7:0]               r_center_r;

  // Output register.
  logic                     out_valid_r;
  logic [7:0]               out_pixel_r, sel_pix;
  logic                     out_last_r;
  logic [imf_pkg::RANK_W-1:0] target;

  // The whole pipeline advances unless a result is held at the output.
  assign en  = !out_valid_r || !out_stall;
  assign pop = en && job_valid;

  // Map banks to row offsets from two rows above to two rows below.
  always_comb begin
    for (int d = 0; d < imf_pkg::WIN; d++) begin
      col_a_rot[d] = job.col_a[imf_pkg::wrap5(4'(job.slot) + 4'(d) + 4'd3)];
      col_b_rot[d] = job.col_b[imf_pkg::wrap5(4'(job.slot) + 4'(d) + 4'd3)];
    end
  end

  // Column shift window and the buffer for the first columns of a row.
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int d = 0; d < imf_pkg::WIN; d++) begin
        for (int k = 0; k < imf_pkg::WIN - 1; k++) begin
          win_r[d][k] <= win_r[d][k+1];
        end
        win_r[d][imf_pkg::WIN-1] <= col_a_rot[d];
        if (job.col < 2) begin
          bbuf_r[job.col[0]][d] <= col_b_rot[d];
        end
      end
      w_col_r    <= job.col;
      w_five_r   <= job.five;
      w_border_r <= job.border;
      w_last_r   <= job.last;
    end
  end

  // Compose the window and compare every pair; ties broken by position.
  always_comb begin
    logic [imf_pkg::COL_W:0] pos;
    logic [imf_pkg::COL_W:0] bpos;
    for (int d = 0; d < imf_pkg::WIN; d++) begin
      for (int k = 0; k < imf_pkg::WIN; k++) begin
        pos  = {1'b0, w_col_r} + (imf_pkg::COL_W + 1)'(k);
        bpos = pos + (w_five_r ? (imf_pkg::COL_W + 1)'(2) : (imf_pkg::COL_W + 1)'(1))
             - (imf_pkg::COL_W + 1)'(4);
        comp[d*imf_pkg::WIN + k] = (pos < (imf_pkg::COL_W + 1)'(4)) ? bbuf_r[bpos[0]][d]
                                                                     : win_r[d][k];
        act[d*imf_pkg::WIN + k]  = w_five_r || ((d >= 1) && (d <= 3) && (k >= 2));
      end
    end
    center = w_five_r ? comp[2*imf_pkg::WIN + 2] : comp[2*imf_pkg::WIN + 3];
    for (int i = 0; i < imf_pkg::NWIN; i++) begin
      for (int j = 0; j < imf_pkg::NWIN; j++) begin
        lt[i][j] = act[j] && ((comp[j] < comp[i]) || ((comp[j] == comp[i]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_lt_r     <= lt;
      c_val_r    <= comp;
      c_act_r    <= act;
      c_five_r   <= w_five_r;
      c_border_r <= w_border_r;
      c_last_r   <= w_last_r;
      c_center_r <= center;
    end
  end

  // Rank of each element among the active ones.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < imf_pkg::NWIN; i++) begin
        r_rank_r[i] <= imf_pkg::RANK_W'($countones(c_lt_r[i]));
      end
      r_val_r    <= c_val_r;
      r_act_r    <= c_act_r;
      r_five_r   <= c_five_r;
      r_border_r <= c_border_r;
      r_last_r   <= c_last_r;
      r_center_r <= c_center_r;
    end
  end

  // Pick the element whose rank is the median position.
  always_comb begin
    target  = r_five_r ? imf_pkg::MED_RANK_5 : imf_pkg::MED_RANK_3;
    sel_pix = '0;
    for (int i = 0; i < imf_pkg::NWIN; i++) begin
      if (r_act_r[i] && (r_rank_r[i] == target)) begin
        sel_pix = sel_pix | r_val_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pixel_r <= r_border_r ? r_center_r : sel_pix;
      out_last_r  <= r_last_r;
    end
  end

  // Valid flags of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      r_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      w_valid_r   <= job_valid;
      c_valid_r   <= w_valid_r;
      r_valid_r   <= c_valid_r;
      out_valid_r <= r_valid_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_frame_end = out_last_r;

endmodule

### src/imf_checker.sv
// Port-level checks of the median filter, bound to the top level.
module imf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [7:0]                 out_pixel_out,
  input logic                       out_frame_end,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [imf_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                pwdata,
  input logic [31:0]                prdata
);

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pixel_out) && $stable(out_frame_end))
    else $error("result changed while stalled");

  // No result straight after reset.
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result offered straight after reset");

  // The low eleven bits of a width written read back unchanged.
  a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && (paddr[3:2] == imf_pkg::REG_FRAME_WIDTH)
    |=> (paddr[3:2] != imf_pkg::REG_FRAME_WIDTH) || ($past(pwdata[10:0]) == prdata[10:0]))
    else $error("frame width read back wrong");

endmodule

bind image_median_filter imf_checker u_imf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pixel_out (out_pixel_out),
  .out_frame_end (out_frame_end),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);
